### src/tkst_pkg.sv
// shared types and constants for the top-k sorted insertion table
// used by tkst_cell and top_k_sorted_insert_table
package tkst_pkg;

	localparam int CAPACITY = 10;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int POS_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_CLEAR  = 2'd1,
		OP_READ   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef struct packed {
		logic [31:0] score;
		logic [31:0] date;
		logic [15:0] days;
		logic [31:0] tag;
	} entry_t;

	typedef struct packed {
		logic insert;
		logic clear;
	} cell_ctl_t;

	typedef struct packed {
		entry_t entry;
		logic   valid;
		logic   take;
	} cell_out_t;

endpackage

### src/tkst_cell.sv
// one slot of the sorted table: holds an entry, compares it with the new score
// and either keeps it, loads the new entry or loads its upper neighbor
// depends on tkst_pkg
module tkst_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  tkst_pkg::cell_ctl_t ctl,
	input  tkst_pkg::entry_t   new_entry,
	input  tkst_pkg::cell_out_t prev,
	output tkst_pkg::cell_out_t cur
);

	tkst_pkg::entry_t entry_q;
	logic             valid_q;
	logic             take;

	// new entry belongs at or above this slot
	assign take = ctl.insert & (~valid_q | (new_entry.score > entry_q.score));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= prev.take ? prev.valid : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			entry_q <= prev.take ? prev.entry : new_entry;
		end
	end

	assign cur.entry = entry_q;
	assign cur.valid = valid_q;
	assign cur.take  = take;

endmodule

### src/top_k_sorted_insert_table.sv
// top level of the top-k sorted insertion table: a chain of tkst_cell slots,
// the entry counter and the registered result port; depends on tkst_pkg
//
// A command is taken on any cycle with start high (busy stays low), and its
// result is registered and shows in the next cycle, for exactly one cycle
// with done high; the receiver cannot stall it. Each insert compares the new
// score against every slot at once and shifts the lower slots down by one in
// the same cycle, so commands may be issued every cycle. A read sees the
// state left by all earlier commands. Clear empties the whole table.
module top_k_sorted_insert_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [31:0] new_score,
	input  logic [31:0] new_date,
	input  logic [15:0] new_days,
	input  logic [31:0] land_tag,
	input  logic [3:0]  read_index,
	output logic        done,
	output logic        placed,
	output logic [3:0]  rank,
	output logic [3:0]  entry_count,
	output logic        read_valid,
	output logic [31:0] read_score,
	output logic [31:0] read_date,
	output logic [15:0] read_days,
	output logic [31:0] read_tag
);

	tkst_pkg::op_t       op;
	tkst_pkg::cell_ctl_t ctl;
	tkst_pkg::entry_t    new_entry;
	tkst_pkg::cell_out_t chain [tkst_pkg::CAPACITY + 1];

	logic [tkst_pkg::CNT_W-1:0] count_q;
	logic [tkst_pkg::CNT_W-1:0] count_nxt;
	logic [tkst_pkg::POS_W-1:0] pos;
	logic                       hit;
	logic                       accept;
	logic                       ins_placed;
	tkst_pkg::entry_t           rd_entry;

	logic        done_q;
	logic        placed_q;
	logic [3:0]  rank_q;
	logic [3:0]  count_out_q;
	logic        read_valid_q;
	tkst_pkg::entry_t read_q;

	assign busy   = 1'b0;
	assign accept = start & ~busy;
	assign op     = tkst_pkg::op_t'(operation);

	always_comb begin
		ctl.insert = 1'b0;
		ctl.clear  = 1'b0;
		if (accept) begin
			unique case (op)
				tkst_pkg::OP_INSERT: ctl.insert = 1'b1;
				tkst_pkg::OP_CLEAR:  ctl.clear  = 1'b1;
				tkst_pkg::OP_READ:   ;
				tkst_pkg::OP_NONE:   ;
				default:             ;
			endcase
		end
	end

	assign new_entry.score = new_score;
	assign new_entry.date  = new_date;
	assign new_entry.days  = new_days;
	assign new_entry.tag   = land_tag;

	// head of the chain never takes
	assign chain[0] = '0;

	for (genvar i = 0; i < tkst_pkg::CAPACITY; i++) begin : g_cell
		tkst_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.new_entry (new_entry),
			.prev      (chain[i]),
			.cur       (chain[i+1])
		);
	end

	// take is monotone down the chain, so the last slot tells if the entry fits
	assign ins_placed = chain[tkst_pkg::CAPACITY].take;

	always_comb begin
		pos = '0;
		for (int i = 0; i < tkst_pkg::CAPACITY; i++) begin
			if (chain[i+1].take && !chain[i].take) begin
				pos = tkst_pkg::POS_W'(i);
			end
		end
	end

	always_comb begin
		hit      = 1'b0;
		rd_entry = '0;
		for (int i = 0; i < tkst_pkg::CAPACITY; i++) begin
			if (int'(read_index) == i && chain[i+1].valid) begin
				hit      = 1'b1;
				rd_entry = chain[i+1].entry;
			end
		end
	end

	always_comb begin
		count_nxt = count_q;
		if (ctl.clear) begin
			count_nxt = '0;
		end else if (ins_placed &&
			count_q < tkst_pkg::CNT_W'(tkst_pkg::CAPACITY)) begin
			count_nxt = count_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			done_q       <= 1'b0;
			placed_q     <= 1'b0;
			rank_q       <= '0;
			count_out_q  <= '0;
			read_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			done_q  <= accept;
			if (accept) begin
				placed_q     <= ins_placed;
				rank_q       <= ins_placed ? 4'(pos) : 4'd0;
				count_out_q  <= 4'(count_nxt);
				read_valid_q <= (op == tkst_pkg::OP_READ) & hit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_q <= ((op == tkst_pkg::OP_READ) && hit) ? rd_entry : '0;
		end
	end

	assign done        = done_q;
	assign placed      = placed_q;
	assign rank        = rank_q;
	assign entry_count = count_out_q;
	assign read_valid  = read_valid_q;
	assign read_score  = read_q.score;
	assign read_date   = read_q.date;
	assign read_days   = read_q.days;
	assign read_tag    = read_q.tag;

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("result beat missing after accepted command");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= tkst_pkg::CNT_W'(tkst_pkg::CAPACITY))
		else $error("entry count beyond capacity");

	a_rank_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(done && placed) |-> (rank < entry_count))
		else $error("placed rank outside valid entries");

	a_read_not_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(done && read_valid) |-> !placed)
		else $error("read and placement in one beat");

endmodule
